[rtl/afle_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afle_pkg: shared types and constants for the ANSI-filtered line editor
// Holds the channel payload structs, the command queue entry, the command
// kind codes and the character constants used by the front and back parts.
// ----------------------------------------------------------------------------
package afle_pkg;

  // Line store geometry
  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
  // Common compare width, wide enough for any depth up to 256
  localparam int CMP_W      = 9;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Operation codes on the input channel
  localparam logic [1:0] OP_RX_BYTE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Line events on the result channel
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_LINE  = 2'd1;
  localparam logic [1:0] EV_KEY   = 2'd2;

  // Characters
  localparam logic [7:0] CH_ESC     = 8'h1b;
  localparam logic [7:0] CH_BRACKET = 8'h5b;
  localparam logic [7:0] CH_BS      = 8'h08;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Escape filter: last position before a sequence is abandoned
  localparam logic [2:0] ESC_IDLE  = 3'd0;
  localparam logic [2:0] ESC_OPEN  = 3'd1;
  localparam logic [2:0] ESC_BODY  = 3'd2;
  localparam logic [2:0] ESC_LIMIT = 3'd5;

  // Command kinds passed from front to back
  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_CLEAR = 3'd1;
  localparam logic [2:0] CMD_KEY   = 3'd2;
  localparam logic [2:0] CMD_BS    = 3'd3;
  localparam logic [2:0] CMD_NL    = 3'd4;
  localparam logic [2:0] CMD_PLAIN = 3'd5;

  // Backspace echo phases
  localparam logic [1:0] BS_IDLE  = 2'd0;
  localparam logic [1:0] BS_SPACE = 2'd1;
  localparam logic [1:0] BS_FINAL = 2'd2;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic [1:0] line_event;
    logic [6:0] line_length;
    logic [7:0] read_byte;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [5:0] index;
  } cmd_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
  } q_status_t;

  // Fit a line count into the result's length field
  function automatic logic [6:0] to_len(input logic [CNT_W-1:0] cnt);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(cnt);
    return ext[6:0];
  endfunction

endpackage

[rtl/afle_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afle_front: input acceptance and escape filtering
// Accepts input transfers, runs the ANSI escape filter and turns each item
// into a command for the back part, or drops it.
// ----------------------------------------------------------------------------
module afle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  afle_pkg::in_item_t  in_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  afle_pkg::q_status_t q_status,
  output logic                push,
  output afle_pkg::cmd_t      push_cmd
);

  logic       wait_key_r;
  logic [2:0] esc_pos_r;
  logic [2:0] esc_pos_nxt;
  logic       accept;
  logic       pass;
  logic       is_letter;
  logic       is_rx;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;
  assign is_rx    = (in_data.operation == afle_pkg::OP_RX_BYTE);

  assign is_letter = ((in_data.rx_byte >= 8'h41) && (in_data.rx_byte <= 8'h5a)) ||
                     ((in_data.rx_byte >= 8'h61) && (in_data.rx_byte <= 8'h7a));

  // Advance the escape filter for one received byte
  always_comb begin
    esc_pos_nxt = esc_pos_r;
    pass        = 1'b0;
    if (esc_pos_r == afle_pkg::ESC_IDLE) begin
      if (in_data.rx_byte == afle_pkg::CH_ESC) begin
        esc_pos_nxt = afle_pkg::ESC_OPEN;
      end else begin
        pass = 1'b1;
      end
    end else if (esc_pos_r == afle_pkg::ESC_OPEN) begin
      if (in_data.rx_byte == afle_pkg::CH_BRACKET) begin
        esc_pos_nxt = afle_pkg::ESC_BODY;
      end else begin
        esc_pos_nxt = afle_pkg::ESC_IDLE;
        pass        = 1'b1;
      end
    end else if (is_letter) begin
      esc_pos_nxt = afle_pkg::ESC_IDLE;
    end else if (esc_pos_r > afle_pkg::ESC_LIMIT) begin
      esc_pos_nxt = afle_pkg::ESC_IDLE;
    end else begin
      esc_pos_nxt = esc_pos_r + 3'd1;
    end
  end

  // Classify the item into a command
  always_comb begin
    push          = 1'b0;
    push_cmd.kind = afle_pkg::CMD_PLAIN;
    push_cmd.data = in_data.rx_byte;
    push_cmd.index = in_data.read_index;
    unique case (in_data.operation)
      afle_pkg::OP_RX_BYTE: begin
        if (wait_key_r) begin
          push          = accept;
          push_cmd.kind = afle_pkg::CMD_KEY;
        end else if (pass) begin
          push = accept;
          if (in_data.rx_byte == afle_pkg::CH_BS) begin
            push_cmd.kind = afle_pkg::CMD_BS;
          end else if (in_data.rx_byte == afle_pkg::CH_NL) begin
            push_cmd.kind = afle_pkg::CMD_NL;
          end else begin
            push_cmd.kind = afle_pkg::CMD_PLAIN;
          end
        end
      end
      afle_pkg::OP_READ: begin
        push          = accept;
        push_cmd.kind = afle_pkg::CMD_READ;
      end
      afle_pkg::OP_CLEAR: begin
        push          = accept;
        push_cmd.kind = afle_pkg::CMD_CLEAR;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Hold mode register and filter position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_key_r <= 1'b0;
      esc_pos_r  <= afle_pkg::ESC_IDLE;
    end else begin
      if (cfg_wr_en) begin
        wait_key_r <= cfg_wr_data;
      end
      if (accept && is_rx) begin
        esc_pos_r <= esc_pos_nxt;
      end
    end
  end

endmodule

[rtl/afle_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afle_queue: command queue between front and back
// Short FIFO that lets the front keep accepting while the back is busy
// echoing or its output is stalled.
// ----------------------------------------------------------------------------
module afle_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  afle_pkg::cmd_t      push_cmd,
  output afle_pkg::q_status_t q_status,
  output logic                q_valid,
  output afle_pkg::cmd_t      q_head,
  input  logic                pop
);

  afle_pkg::cmd_t                    entry_r [afle_pkg::QUEUE_DEPTH];
  logic [afle_pkg::QPTR_W-1:0]       wr_ptr_r;
  logic [afle_pkg::QPTR_W-1:0]       rd_ptr_r;
  logic [afle_pkg::QCNT_W-1:0]       cnt_r;
  logic                              do_push;
  logic                              do_pop;

  assign q_valid       = (cnt_r != '0);
  assign q_status.full = (cnt_r == afle_pkg::QCNT_W'(afle_pkg::QUEUE_DEPTH));
  assign q_head        = entry_r[rd_ptr_r];
  assign do_push       = push && !q_status.full;
  assign do_pop        = pop && q_valid;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

[rtl/afle_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afle_back: line store, edit execution and result register
// Pops commands, updates line store and count, drives results through an
// output register; backspace on a non-empty line issues three in a row.
// ----------------------------------------------------------------------------
module afle_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  afle_pkg::cmd_t      q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output afle_pkg::out_item_t out_data
);

  logic [7:0]                  mem [afle_pkg::LINE_DEPTH];
  logic [7:0]                  mem_q_r;
  logic [afle_pkg::CNT_W-1:0]  cnt_r;
  logic [afle_pkg::CNT_W-1:0]  cnt_nxt;
  logic [1:0]                  bs_phase_r;
  logic [1:0]                  bs_phase_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic                        echo_valid_r;
  logic                        echo_valid_nxt;
  logic [7:0]                  echo_byte_r;
  logic [7:0]                  echo_byte_nxt;
  logic [1:0]                  event_r;
  logic [1:0]                  event_nxt;
  logic [6:0]                  len_r;
  logic [6:0]                  len_nxt;
  logic                        rd_sel_r;
  logic                        rd_sel_nxt;
  logic                        last_r;
  logic                        last_nxt;
  logic                        out_free;
  logic                        load;
  logic                        wr_en;
  logic                        rd_en;
  logic                        in_range;
  logic [afle_pkg::CMP_W-1:0]  idx_ext;
  logic [afle_pkg::ADDR_W-1:0] rd_addr;
  logic [afle_pkg::ADDR_W-1:0] wr_addr;
  logic                        not_full;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = q_valid && (bs_phase_r == afle_pkg::BS_IDLE) && out_free;
  assign idx_ext  = afle_pkg::CMP_W'(q_head.index);
  assign in_range = (idx_ext < afle_pkg::CMP_W'(cnt_r)) &&
                    (idx_ext < afle_pkg::CMP_W'(afle_pkg::LINE_DEPTH));
  assign rd_addr  = idx_ext[afle_pkg::ADDR_W-1:0];
  assign wr_addr  = afle_pkg::ADDR_W'(cnt_r);
  assign not_full = (afle_pkg::CMP_W'(cnt_r) < afle_pkg::CMP_W'(afle_pkg::LINE_DEPTH));
  assign rd_en    = pop && (q_head.kind == afle_pkg::CMD_READ);

  // Execute the head command or the next backspace echo
  always_comb begin
    cnt_nxt        = cnt_r;
    bs_phase_nxt   = bs_phase_r;
    out_valid_nxt  = out_valid_r && out_stall;
    echo_valid_nxt = echo_valid_r;
    echo_byte_nxt  = echo_byte_r;
    event_nxt      = event_r;
    rd_sel_nxt     = rd_sel_r;
    last_nxt       = last_r;
    load           = 1'b0;
    wr_en          = 1'b0;
    if ((bs_phase_r != afle_pkg::BS_IDLE) && out_free) begin
      load           = 1'b1;
      echo_valid_nxt = 1'b1;
      echo_byte_nxt  = (bs_phase_r == afle_pkg::BS_SPACE) ? afle_pkg::CH_SPACE
                                                          : afle_pkg::CH_BS;
      event_nxt      = afle_pkg::EV_NONE;
      rd_sel_nxt     = 1'b0;
      last_nxt       = (bs_phase_r == afle_pkg::BS_FINAL);
      bs_phase_nxt   = (bs_phase_r == afle_pkg::BS_SPACE) ? afle_pkg::BS_FINAL
                                                          : afle_pkg::BS_IDLE;
    end else if (pop) begin
      echo_valid_nxt = 1'b0;
      echo_byte_nxt  = 8'h00;
      event_nxt      = afle_pkg::EV_NONE;
      rd_sel_nxt     = 1'b0;
      last_nxt       = 1'b1;
      unique case (q_head.kind)
        afle_pkg::CMD_READ: begin
          load       = 1'b1;
          rd_sel_nxt = in_range;
        end
        afle_pkg::CMD_CLEAR: begin
          load    = 1'b1;
          cnt_nxt = '0;
        end
        afle_pkg::CMD_KEY: begin
          load      = 1'b1;
          event_nxt = afle_pkg::EV_KEY;
        end
        afle_pkg::CMD_BS: begin
          if (cnt_r != '0) begin
            load           = 1'b1;
            cnt_nxt        = cnt_r - 1'b1;
            echo_valid_nxt = 1'b1;
            echo_byte_nxt  = afle_pkg::CH_BS;
            last_nxt       = 1'b0;
            bs_phase_nxt   = afle_pkg::BS_SPACE;
          end
        end
        afle_pkg::CMD_NL: begin
          load           = 1'b1;
          echo_valid_nxt = 1'b1;
          echo_byte_nxt  = afle_pkg::CH_NL;
          event_nxt      = afle_pkg::EV_LINE;
        end
        afle_pkg::CMD_PLAIN: begin
          if (not_full) begin
            load           = 1'b1;
            wr_en          = 1'b1;
            cnt_nxt        = cnt_r + 1'b1;
            echo_valid_nxt = 1'b1;
            echo_byte_nxt  = q_head.data;
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
    if (load) begin
      out_valid_nxt = 1'b1;
    end
    len_nxt = load ? afle_pkg::to_len(cnt_nxt) : len_r;
  end

  // Line store: write at the line end, registered read for read commands
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_head.data;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    echo_valid_r <= echo_valid_nxt;
    echo_byte_r  <= echo_byte_nxt;
    event_r      <= event_nxt;
    len_r        <= len_nxt;
    rd_sel_r     <= rd_sel_nxt;
    last_r       <= last_nxt;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      bs_phase_r  <= afle_pkg::BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      bs_phase_r  <= bs_phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.echo_valid  = echo_valid_r;
  assign out_data.echo_byte   = echo_byte_r;
  assign out_data.line_event  = event_r;
  assign out_data.line_length = len_r;
  assign out_data.read_byte   = rd_sel_r ? mem_q_r : 8'h00;
  assign out_data.last        = last_r;

endmodule

[rtl/ansi_filtered_line_editor_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_filtered_line_editor_core: terminal line editor with escape filter
// Outside wait-key mode, drops ANSI escape sequences from received bytes
// and edits the rest into a line store with echo; serves reads and clears.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                         | Direction | Payload
//  --------+-------------------------------+-----------+---------------------
//  input   | in_valid, in_stall, in_data   | in        | afle_pkg::in_item_t
//  result  | out_valid, out_stall, out_data| out       | afle_pkg::out_item_t
//  config  | cfg_wr_en, cfg_wr_data        | in        | wait_key_mode bit
//
//  One input transfer per cycle is taken while the two-entry command queue
//  has room; the first result of an item is registered at the edge at which
//  its command leaves the queue, held back while a backspace echo runs or the
//  result register is stalled. Most items give one result per cycle while
//  out_stall is low; backspace gives three results in turn (BS, space, BS).
//  Filtered bytes and unused operation codes are dropped by the front and
//  never reach the queue; backspace on an empty line and bytes for a full
//  store are popped from the queue with no result.
//  in_stall depends only on queue occupancy, never directly on out_stall.
//  Reset is synchronous and active low; the line store needs no clearing
//  pass, so items are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module ansi_filtered_line_editor_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  afle_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output afle_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);

  afle_pkg::q_status_t q_status;
  afle_pkg::cmd_t      push_cmd;
  afle_pkg::cmd_t      q_head;
  logic                push;
  logic                q_valid;
  logic                pop;

  afle_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_status   (q_status),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  afle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_status (q_status),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop)
  );

  afle_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

[rtl/afle_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afle_checker: port-level checks for the line editor
// Watches the result channel for handshake and field consistency.
// ----------------------------------------------------------------------------
module afle_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input afle_pkg::out_item_t out_data
);

  // Hold valid while stalled
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result valid dropped while stalled");

  // Hold payload while stalled
  a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // Zero echo byte when no echo is sent
  a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.echo_valid |-> out_data.echo_byte == 8'h00)
    else $error("echo byte set without echo");

  // Read data only appears on a single silent result
  a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_byte != 8'h00) |->
      !out_data.echo_valid && (out_data.line_event == afle_pkg::EV_NONE) &&
      out_data.last)
    else $error("read byte on a non-read result");

  // Keep the line length within the store
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.line_length) <= afle_pkg::LINE_DEPTH)
    else $error("line length beyond store depth");

endmodule

bind ansi_filtered_line_editor_core afle_checker u_afle_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
